// ----- hdl/sva_pkg.sv -----
// Shared types and constants of the sound voice allocator.
package sva_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUND_COUNT  = 8'd1;

	// Input item kinds.
	localparam logic KIND_PLAY = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Priority value that marks an unused voice, and the level ceiling.
	localparam logic [7:0] FREE_PRIO = 8'hFF;
	localparam logic [6:0] LEVEL_MAX = 7'd64;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;   // capture the input item and clear the scan state
		logic step;   // examine one voice entry
		logic commit; // update the voice table and load the result register
	} sva_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic skip;   // the item needs no scan
		logic last;   // the scan is at the last voice
	} sva_sts_t;

endpackage

// ----- hdl/sva_ctrl.sv -----
// Controller state machine of the sound voice allocator.
module sva_ctrl import sva_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  sva_sts_t sts,
	output sva_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.skip) begin
					state_d = ST_DONE;
				end else begin
					cmd.step = 1'b1;
					if (sts.last) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				// Wait for the result register to drain before overwriting it.
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/sva_datapath.sv -----
// Datapath of the sound voice allocator: voice table, scan unit and result register.
module sva_datapath import sva_pkg::*; #(
	parameter int unsigned VOICES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sva_cmd_t          cmd,
	output sva_sts_t          sts,
	input  logic              kind,
	input  logic [15:0]       sound_id,
	input  logic signed [8:0] volume,
	input  logic signed [7:0] priority_req,
	input  logic              no_duplicate,
	input  logic [2:0]        done_voice,
	input  logic              sound_enable,
	input  logic [15:0]       sound_count,
	output logic              started,
	output logic [2:0]        voice,
	output logic              stole,
	output logic [6:0]        level,
	output logic [15:0]       play_id,
	output logic              bad_request
);

	localparam int unsigned IDX_W = $clog2(VOICES);

	// Voice table.
	logic signed [7:0] prio_q  [VOICES];
	logic [31:0]       stamp_q [VOICES];
	logic [15:0]       sound_q [VOICES];
	logic [31:0]       stamp_cnt_q;

	// Captured item.
	logic              kind_q;
	logic [15:0]       id_q;
	logic signed [8:0] vol_q;
	logic signed [7:0] prio_req_q;
	logic              nodup_q;
	logic [2:0]        done_q;

	// Scan state.
	logic [IDX_W-1:0]  idx_q;
	logic              dup_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic signed [7:0] best_prio_q;
	logic [31:0]       best_stamp_q;
	logic [IDX_W-1:0]  best_idx_q;

	// Result register.
	logic              started_q;
	logic [2:0]        voice_q;
	logic              stole_q;
	logic [6:0]        level_q;
	logic [15:0]       play_id_q;
	logic              bad_q;

	logic signed [7:0] ent_prio;
	logic [31:0]       ent_stamp;
	logic [15:0]       ent_sound;
	logic              ent_better;
	logic              drop_lvl;
	logic [6:0]        lvl;
	logic              bad;
	logic              done_ok;
	logic [IDX_W-1:0]  done_idx;
	logic [IDX_W-1:0]  sel_idx;

	assign ent_prio  = prio_q[idx_q];
	assign ent_stamp = stamp_q[idx_q];
	assign ent_sound = sound_q[idx_q];

	// Lower priority wins, an older stamp breaks a tie, the earlier index a full tie.
	assign ent_better = (idx_q == '0) || (ent_prio < best_prio_q) ||
		((ent_prio == best_prio_q) && ($signed(ent_stamp) < $signed(best_stamp_q)));

	// Halving rounds toward zero, so minus one still gives level zero.
	assign drop_lvl = vol_q[8] && (vol_q != -9'sd1);
	assign lvl      = vol_q[8] ? 7'd0 : ((vol_q[7:1] > LEVEL_MAX) ? LEVEL_MAX : vol_q[7:1]);
	assign bad      = (id_q >= sound_count) || prio_req_q[7];
	assign done_ok  = (32'(done_q) < 32'(VOICES));
	assign done_idx = IDX_W'(done_q);
	assign sel_idx  = free_q ? free_idx_q : best_idx_q;

	assign sts.skip = (kind_q == KIND_DONE) || !sound_enable || drop_lvl;
	assign sts.last = (idx_q == IDX_W'(VOICES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				prio_q[i] <= FREE_PRIO;
			end
			stamp_cnt_q <= '0;
		end else if (cmd.commit) begin
			if (kind_q == KIND_DONE) begin
				if (done_ok) begin
					prio_q[done_idx] <= FREE_PRIO;
				end
			end else if (!sts.skip && !dup_q) begin
				prio_q[sel_idx] <= prio_req_q;
				stamp_cnt_q     <= stamp_cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (kind_q == KIND_PLAY) && !sts.skip && !dup_q) begin
			stamp_q[sel_idx] <= stamp_cnt_q;
			sound_q[sel_idx] <= id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= kind;
			id_q       <= sound_id;
			vol_q      <= volume;
			prio_req_q <= priority_req;
			nodup_q    <= no_duplicate;
			done_q     <= done_voice;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			dup_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q  <= '0;
			dup_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
			if (nodup_q && (ent_prio != FREE_PRIO) && (ent_sound == id_q)) begin
				dup_q <= 1'b1;
			end
			if (!free_q && ent_prio[7]) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (!free_q && ent_prio[7]) begin
				free_idx_q <= idx_q;
			end
			if (ent_better) begin
				best_prio_q  <= ent_prio;
				best_stamp_q <= ent_stamp;
				best_idx_q   <= idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			started_q <= 1'b0;
			voice_q   <= '0;
			stole_q   <= 1'b0;
			level_q   <= '0;
			play_id_q <= '0;
			bad_q     <= 1'b0;
			if (!sts.skip) begin
				bad_q <= bad;
				if (!dup_q) begin
					started_q <= 1'b1;
					voice_q   <= 3'(sel_idx);
					stole_q   <= !free_q;
					level_q   <= lvl;
					play_id_q <= id_q;
				end
			end
		end
	end

	assign started     = started_q;
	assign voice       = voice_q;
	assign stole       = stole_q;
	assign level       = level_q;
	assign play_id     = play_id_q;
	assign bad_request = bad_q;

endmodule

// ----- hdl/sound_voice_allocator.sv -----
// Top level of the sound voice allocator with its configuration registers.
// A scanned request walks the whole voice table, duplicates included; items that skip the
// scan (finished, disabled, dropped) go on to the commit without reading the table.
// The scan reads one voice entry per cycle, and a new item is taken only once the previous
// one is committed, while the previous result may still wait in the output register.
// Reset: arst_n clears the controller, frees every voice, zeroes the stamp counter and
// returns sound_enable and sound_count to zero.
module sound_voice_allocator import sva_pkg::*; #(
	parameter int unsigned VOICES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Item input channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [15:0]          sound_id,
	input  logic signed [8:0]    volume,
	input  logic signed [7:0]    priority_req,
	input  logic                 no_duplicate,
	input  logic [2:0]           done_voice,
	// Result output channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 started,
	output logic [2:0]           voice,
	output logic                 stole,
	output logic [6:0]           level,
	output logic [15:0]          play_id,
	output logic                 bad_request,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	sva_cmd_t    cmd;
	sva_sts_t    sts;
	logic        sound_enable_q;
	logic [15:0] sound_count_q;

	// Configuration writes are always taken, as cfg_ready is tied high. An index beyond the register
	// list completes its transfer and changes nothing.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_enable_q <= 1'b0;
			sound_count_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SOUND_ENABLE: sound_enable_q <= cfg_data[0];
				CFG_SOUND_COUNT:  sound_count_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The controller sequences capture, the voice scan and the commit; it also owns the
	// valid flag of the result register so that the input side stays free while a result waits.
	sva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the voice table, walks it one entry per cycle looking for a
	// duplicate, the first free voice and the steal victim, then commits the choice.
	sva_datapath #(
		.VOICES (VOICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.sound_id     (sound_id),
		.volume       (volume),
		.priority_req (priority_req),
		.no_duplicate (no_duplicate),
		.done_voice   (done_voice),
		.sound_enable (sound_enable_q),
		.sound_count  (sound_count_q),
		.started      (started),
		.voice        (voice),
		.stole        (stole),
		.level        (level),
		.play_id      (play_id),
		.bad_request  (bad_request)
	);

endmodule

// ----- tb/sound_voice_checker.sv -----
`timescale 1ns / 100ps
// Checker for the sound voice allocator: predicts every result and compares it on transfer.
module sound_voice_checker import sva_pkg::*; #(
	parameter int unsigned VOICES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 kind,
	input  logic [15:0]          sound_id,
	input  logic signed [8:0]    volume,
	input  logic signed [7:0]    priority_req,
	input  logic                 no_duplicate,
	input  logic [2:0]           done_voice,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 started,
	input  logic [2:0]           voice,
	input  logic                 stole,
	input  logic [6:0]           level,
	input  logic [15:0]          play_id,
	input  logic                 bad_request,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   outstanding,
	output int                   failures
);

	typedef struct packed {
		logic        started;
		logic [2:0]  voice;
		logic        stole;
		logic [6:0]  level;
		logic [15:0] play_id;
		logic        bad_request;
	} alloc_result_t;

	// Shadow copy of the voice table and the registers.
	logic signed [7:0] slot_prio [VOICES];
	logic [31:0]       slot_stamp [VOICES];
	logic [15:0]       slot_sound [VOICES];
	logic [31:0]       stamp_next;
	logic              enable_reg;
	logic [15:0]       count_reg;

	alloc_result_t awaited_results [$];
	alloc_result_t head;
	int mismatches = 0;

	initial begin
		outstanding = 0;
		failures = 0;
	end

	task automatic report(input string what, input int got, input int want_v);
		$display("%0t ns: result mismatch on %s: got %0d, expected %0d", $time, what, got, want_v);
		mismatches++;
	endtask

	// Works out the result of one item and updates the shadow voice table.
	function automatic alloc_result_t allocate_voice(input logic k, input logic [15:0] id,
		input logic signed [8:0] vol, input logic signed [7:0] prio,
		input logic nodup, input logic [2:0] dv);
		alloc_result_t res;
		int half;
		int pick;
		res = '0;
		if (k == KIND_DONE) begin
			if (dv < VOICES)
				slot_prio[dv] = FREE_PRIO;
			return res;
		end
		if (!enable_reg)
			return res;
		half = int'(vol) / 2;
		if (half < 0)
			return res;
		if (half > int'(LEVEL_MAX))
			half = int'(LEVEL_MAX);
		res.bad_request = (id >= count_reg) || (prio < 0);
		if (nodup) begin
			for (int i = 0; i < VOICES; i++)
				if (slot_prio[i] != FREE_PRIO && slot_sound[i] == id)
					return res;
		end
		pick = -1;
		for (int i = 0; i < VOICES; i++)
			if (pick < 0 && slot_prio[i] < 0)
				pick = i;
		if (pick < 0) begin
			// Every voice busy: lowest priority loses, then the oldest signed stamp.
			pick = 0;
			for (int i = 1; i < VOICES; i++)
				if (slot_prio[i] < slot_prio[pick] ||
				    (slot_prio[i] == slot_prio[pick] &&
				     $signed(slot_stamp[i]) < $signed(slot_stamp[pick])))
					pick = i;
			res.stole = 1'b1;
		end
		slot_prio[pick] = prio;
		slot_stamp[pick] = stamp_next;
		slot_sound[pick] = id;
		stamp_next = stamp_next + 32'd1;
		res.started = 1'b1;
		res.voice = pick[2:0];
		res.level = half[6:0];
		res.play_id = id;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				slot_prio[i] = FREE_PRIO;
				slot_stamp[i] = '0;
				slot_sound[i] = '0;
			end
			stamp_next = '0;
			enable_reg = 1'b0;
			count_reg = '0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SOUND_ENABLE: enable_reg = cfg_data[0];
					CFG_SOUND_COUNT:  count_reg = cfg_data;
					default: ;
				endcase
			end
			// Results leave before the new item enters, so a same-edge pair stays in order.
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report("unexpected result (started)", started, -1);
				end else begin
					head = awaited_results.pop_front();
					if (started !== head.started)
						report("started", started, head.started);
					if (voice !== head.voice)
						report("voice", voice, head.voice);
					if (stole !== head.stole)
						report("stole", stole, head.stole);
					if (level !== head.level)
						report("level", level, head.level);
					if (play_id !== head.play_id)
						report("play_id", play_id, head.play_id);
					if (bad_request !== head.bad_request)
						report("bad_request", bad_request, head.bad_request);
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(allocate_voice(kind, sound_id, volume,
					priority_req, no_duplicate, done_voice));
			outstanding <= awaited_results.size();
		end
	end

	always @(posedge clk)
		failures <= mismatches;

endmodule

// ----- tb/tb_sound_voice_allocator.sv -----
`timescale 1ns / 100ps
// Top of the sound voice allocator testbench: stimulus, idling control and the verdict.
module tb_sound_voice_allocator;
	import sva_pkg::*;

	localparam int unsigned VOICES = 8;
	// Cycles the result side refuses in the pressure phase, so the block backs up.
	localparam int HOLD_CYCLES = 400;
	// Cycles with no transfer at all before the run is called hung. The longest honest
	// quiet stretch is the long hold-off above; random gaps and stalls stay far below it.
	localparam int WATCHDOG_LIMIT = 2000;
	// Settling time after the last result.
	localparam int SETTLE_CYCLES = 2 * (VOICES + 2);

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 kind = KIND_PLAY;
	logic [15:0]          sound_id = '0;
	logic signed [8:0]    volume = '0;
	logic signed [7:0]    priority_req = '0;
	logic                 no_duplicate = 1'b0;
	logic [2:0]           done_voice = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 started;
	logic [2:0]           voice;
	logic                 stole;
	logic [6:0]           level;
	logic [15:0]          play_id;
	logic                 bad_request;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	int outstanding;
	int failures;

	// Idling knobs. The sender's knob is only read by the stimulus process itself; the
	// receiver's is written with nonblocking assignments because another process reads it.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sound_voice_allocator #(.VOICES(VOICES)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .sound_id(sound_id), .volume(volume),
		.priority_req(priority_req), .no_duplicate(no_duplicate), .done_voice(done_voice),
		.out_valid(out_valid), .out_ready(out_ready),
		.started(started), .voice(voice), .stole(stole), .level(level),
		.play_id(play_id), .bad_request(bad_request),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sound_voice_checker #(.VOICES(VOICES)) CHK (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .sound_id(sound_id), .volume(volume),
		.priority_req(priority_req), .no_duplicate(no_duplicate), .done_voice(done_voice),
		.out_valid(out_valid), .out_ready(out_ready),
		.started(started), .voice(voice), .stole(stole), .level(level),
		.play_id(play_id), .bad_request(bad_request),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.outstanding(outstanding), .failures(failures)
	);

	// Result side. A new hold request from the stimulus starts a long refusal that this
	// process counts down on its own; otherwise ready drops at random per the stall knob.
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: any transfer on any channel resets the count of quiet cycles.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_sound_voice_allocator: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One register write. It opens with a clock edge so that the valid it raises never
	// shares a time step with the lowering from a previous write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Offers one item and returns at the edge of its transfer. Valid stays high into the
	// next item unless a gap is drawn, in which case it drops for the drawn gap.
	task automatic send_item(input logic k, input logic [15:0] id, input logic signed [8:0] vol,
		input logic signed [7:0] prio, input logic nodup, input logic [2:0] dv);
		int gap;
		gap = 0;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		sound_id <= id;
		volume <= vol;
		priority_req <= prio;
		no_duplicate <= nodup;
		done_voice <= dv;
		do @(posedge clk); while (!in_ready);
	endtask

	// Fields that a play request or a finished event ignores still carry random bits.
	task automatic play(input logic [15:0] id, input int vol, input int prio, input logic nodup);
		send_item(KIND_PLAY, id, 9'(vol), 8'(prio), nodup, 3'($urandom));
	endtask

	task automatic finish_voice(input logic [2:0] dv);
		send_item(KIND_DONE, 16'($urandom), 9'($urandom), 8'($urandom), 1'($urandom), dv);
	endtask

	// Mostly small ids and priorities so that duplicates, reuse and priority ties are
	// common; the rest use the full field ranges.
	task automatic random_item();
		logic              k;
		logic [15:0]       id;
		logic signed [8:0] vol;
		logic signed [7:0] prio;
		k = ($urandom_range(99) < 30) ? KIND_DONE : KIND_PLAY;
		id = ($urandom_range(99) < 80) ? 16'($urandom_range(11)) : 16'($urandom);
		vol = ($urandom_range(99) < 80) ? 9'($urandom_range(200)) : 9'($urandom);
		prio = ($urandom_range(99) < 80) ? 8'($urandom_range(15)) : 8'($urandom);
		send_item(k, id, vol, prio, 1'($urandom), 3'($urandom));
	endtask

	// Lets the block run dry: valid goes low and every awaited result has to arrive.
	// Since every item yields exactly one result, the block is idle once the count is zero.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct <= stall_pct;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Straight after reset the block is disabled, so this is ignored.
		play(16'd5, 100, 3, 1'b0);
		drain();
		write_reg(CFG_SOUND_COUNT, 16'd10);
		write_reg(CFG_SOUND_ENABLE, 16'd1);
		play(16'd0, 255, 127, 1'b0);     // loudest request, level clips
		play(16'd1, -256, 10, 1'b0);     // most negative volume, dropped
		play(16'd9, -1, 5, 1'b0);        // minus one halves to zero and still starts
		play(16'd2, -2, 5, 1'b0);        // minus two halves to minus one, dropped
		play(16'hFFFF, 0, 0, 1'b0);      // id beyond the count is flagged but plays
		play(16'd7, 100, -128, 1'b0);    // negative priority: flagged, voice stays reusable
		play(16'd7, 50, 20, 1'b1);       // same sound still counts as playing, dropped
		play(16'd8, 60, -1, 1'b0);       // lands on the voice with the negative priority
		play(16'd8, 60, -1, 1'b1);       // priority of minus one is not a duplicate
		play(16'd3, 200, 4, 1'b0);
		play(16'd4, 100, 4, 1'b0);
		play(16'd5, 100, 4, 1'b0);
		play(16'd6, 100, 4, 1'b0);
		play(16'd1, 100, 4, 1'b0);       // all eight voices busy from here
		play(16'd2, 80, 4, 1'b0);        // steals the lowest priority
		play(16'd2, 80, 4, 1'b1);        // duplicate of a busy voice, dropped
		play(16'd9, 10, 4, 1'b0);        // equal priorities, the oldest stamp goes
		play(16'd3, 90, 4, 1'b0);
		finish_voice(3'd0);
		finish_voice(3'd7);
		play(16'd10, 120, 127, 1'b0);    // id equal to the count is flagged
		play(16'd4, 30, 2, 1'b0);
		finish_voice(3'd7);              // finishing a voice that is already free

		// Random phases, one idling pattern each, with the registers moved in between.
		drain();
		write_reg(CFG_SOUND_COUNT, 16'd16);
		set_idling(0, 0);
		repeat (200) random_item();

		drain();
		write_reg(CFG_SOUND_COUNT, 16'hFFFF);
		set_idling(45, 0);
		repeat (200) random_item();

		drain();
		write_reg(CFG_SOUND_COUNT, 16'd0);
		set_idling(0, 45);
		repeat (200) random_item();

		drain();
		write_reg(CFG_SOUND_ENABLE, 16'd0);
		set_idling(17, 17);
		repeat (40) random_item();

		drain();
		write_reg(CFG_SOUND_ENABLE, 16'd1);
		write_reg(CFG_SOUND_COUNT, 16'd12);
		repeat (150) random_item();

		// Pressure: the result side holds off for a long stretch while items keep coming,
		// so the output register fills and the input side has to stall.
		drain();
		set_idling(0, 0);
		hold_requests <= hold_requests + 1;
		repeat (60) random_item();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("tb_sound_voice_allocator: PASS");
		end else begin
			$display("tb_sound_voice_allocator: FAIL");
		end
		$finish;
	end

endmodule
